FILE: rtl/psafl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psafl_pkg
// Shared types and constants for the per-source auth failure limiter.
// ----------------------------------------------------------------------------
package psafl_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned KeyW = 33;
  localparam int unsigned TimeW = 32;
  localparam int unsigned FailW = 8;
  localparam int unsigned WinW = 16;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [WinW-1:0] WindowReset = 16'd10;
  localparam logic [FailW-1:0] LimitReset = 8'd20;
  localparam logic [FailW-1:0] FailMax = 8'd255;

  localparam logic [CfgIdxW-1:0] RegWindow = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLimit = 1'b1;

  typedef struct packed {
    logic [31:0] src_addr;
    logic        addr_known;
    logic [31:0] now_seconds;
    logic        credentials_ok;
  } in_word_t;

  typedef struct packed {
    logic               granted;
    logic               throttled;
    logic [IdxOutW-1:0] entry_index;
    logic [FailW-1:0]   fail_after;
  } out_word_t;

  // One table entry as it travels along the chain.
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [FailW-1:0] fails;
    logic [TimeW-1:0] start;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/psafl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psafl_cell
// One table entry; shifts to its neighbor whenever the ring rotates.
// ----------------------------------------------------------------------------
module psafl_cell
  import psafl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  entry_t entry_in,
  output entry_t entry_out
);

  entry_t ent_r;

  // Clear only the valid bit on reset; the payload is ignored while invalid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift) begin
      ent_r <= entry_in;
    end
  end

  assign entry_out = ent_r;

endmodule

FILE: rtl/per_source_auth_fail_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_auth_fail_limiter_top
// Per-key fixed-window failure limiter over a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// Sequence: an accepted word is handled by two full rotations of the cell
//   ring (search pass, then update pass), then ST_DONE; out_valid is
//   registered from ST_DONE. No new word is accepted until busy falls.
// Reset: synchronous active-low rst_n clears all entries to invalid and
//   reloads window_seconds = 10, fail_limit = 20. The receiver cannot stall.
// ----------------------------------------------------------------------------
module per_source_auth_fail_limiter_top
  import psafl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(2 * TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] PassLen = CntW'(TABLE_ENTRIES);
  localparam logic [CntW-1:0] LastCnt = CntW'(2 * TABLE_ENTRIES - 1);

  // Configuration registers.
  logic [WinW-1:0]  win_r;
  logic [FailW-1:0] lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WindowReset;
      lim_r <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegWindow: win_r <= cfg_data[WinW-1:0];
        RegLimit:  lim_r <= cfg_data[FailW-1:0];
        default: ;
      endcase
    end
  end

  // Ring of cells: head is cell 0, data moves from cell i+1 to cell i,
  // head wraps back to the tail. After TABLE_ENTRIES shifts the ring is home.
  entry_t chain [TABLE_ENTRIES];
  entry_t tail_in;
  logic   shift;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    entry_t nb;
    if (g == TABLE_ENTRIES - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_mid
      assign nb = chain[g+1];
    end
    psafl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .entry_in (nb),
      .entry_out(chain[g])
    );
  end

  entry_t head;
  assign head = chain[0];

  // Control.
  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  in_word_t        req_r;
  logic [KeyW-1:0] key_r;
  logic            hit_r, free_r;
  logic [IdxW-1:0] sel_r, free_idx_r, old_idx_r;
  logic [TimeW-1:0] old_age_r;
  out_word_t       res_r;
  logic            res_v_r;

  logic            pass2;
  logic [IdxW-1:0] pos;
  logic [TimeW-1:0] age;
  logic            is_hit;
  logic [IdxW-1:0] tgt;
  entry_t          upd;
  logic [FailW-1:0] f0, f1;
  logic [TimeW-1:0] s0;
  logic            lim, grant;

  assign pass2 = (cnt_r >= PassLen);
  assign pos   = pass2 ? IdxW'(cnt_r - PassLen) : IdxW'(cnt_r);
  assign age   = req_r.now_seconds - head.start;
  assign is_hit = head.valid && (head.key == key_r);
  assign tgt   = hit_r ? sel_r : (free_r ? free_idx_r : old_idx_r);

  // Update of the chosen entry as it passes the head in the second pass.
  always_comb begin
    if (hit_r) begin
      f0 = head.fails;
      s0 = head.start;
    end else begin
      f0 = '0;
      s0 = req_r.now_seconds;
    end
    if ((req_r.now_seconds - s0) >= TimeW'(win_r)) begin
      f0 = '0;
      s0 = req_r.now_seconds;
    end
    lim   = (f0 >= lim_r);
    grant = !lim && req_r.credentials_ok;
    if (grant) begin
      f1 = '0;
    end else if (f0 != FailMax) begin
      f1 = f0 + 1'b1;
    end else begin
      f1 = f0;
    end
    upd.valid = 1'b1;
    upd.key   = key_r;
    upd.fails = f1;
    upd.start = grant ? req_r.now_seconds : s0;
  end

  always_comb begin
    tail_in = head;
    if (state_r == ST_SCAN && pass2 && pos == tgt) begin
      tail_in = upd;
    end
  end

  assign shift = (state_r == ST_SCAN);
  assign busy  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastCnt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= (state_r == ST_DONE);
    end
  end

  // Search pass: first match, first free, oldest window start.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r     <= in_word;
      key_r     <= in_word.addr_known ? {1'b1, in_word.src_addr} : '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      sel_r     <= '0;
      free_idx_r <= '0;
      old_idx_r <= '0;
      old_age_r <= '0;
    end else if (state_r == ST_SCAN && !pass2) begin
      if (is_hit && !hit_r) begin
        hit_r <= 1'b1;
        sel_r <= pos;
      end
      if (!head.valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= pos;
      end
      if (pos == '0 || age > old_age_r) begin
        old_age_r <= age;
        old_idx_r <= pos;
      end
    end
  end

  // Capture the result as the target entry is rewritten.
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && pass2 && pos == tgt) begin
      res_r.granted     <= grant;
      res_r.throttled   <= lim;
      res_r.entry_index <= IdxOutW'(tgt);
      res_r.fail_after  <= f1;
    end
  end

  assign out_valid = res_v_r;
  assign out_word  = res_r;

  // Assertions.
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after start");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DONE))
    else $error("result without finished pass");

  a_no_grant_limited: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.granted && out_word.throttled))
    else $error("grant while rate limited");

  a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.granted) |-> (out_word.fail_after == '0))
    else $error("grant left nonzero count");

endmodule
